>>> hdl/tpst_pkg.sv
// Shared widths, codes and record types of the trajectory point search table.
// No dependencies; every other file of the block imports this package.
package tpst_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int MODE_W = 3;
  localparam int TIME_W = 32;
  localparam int POS_W  = 24;
  localparam int EPS_W  = 16;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 8;
  localparam int PCNT_W = 9;

  // Coordinate difference, its square and the sum of two squares.
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 1;
  // Operand width of the shared unit; covers times plus one guard bit too.
  localparam int OPW    = DIST_W;

  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_LOWER  = 3'd2,
    MODE_NEAR   = 3'd3,
    MODE_SHIFT  = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ORDER = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0] time_v;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } point_t;

  typedef struct packed {
    logic             en_time;
    logic             en_pos;
    logic [IDX_W-1:0] addr;
    point_t           data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

endpackage

>>> hdl/tpst_if.sv
// Valid/ready channel interfaces: request in, result out, configuration write.
// Depends on tpst_pkg for field widths.
interface tpst_in_if;
  import tpst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [TIME_W-1:0] time_value;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  modport source (output valid, mode, time_value, pos_x, pos_y, input ready);
  modport sink   (input valid, mode, time_value, pos_x, pos_y, output ready);
endinterface

interface tpst_out_if;
  import tpst_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FIDX_W-1:0] found_index;
  logic [PCNT_W-1:0] point_count;
  modport source (output valid, status, found_index, point_count, input ready);
  modport sink   (input valid, status, found_index, point_count, output ready);
endinterface

interface tpst_cfg_if;
  import tpst_pkg::*;
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] time_epsilon;
  modport source (output valid, time_epsilon, input ready);
  modport sink   (input valid, time_epsilon, output ready);
endinterface

>>> hdl/tpst_store.sv
// Point table memories: time, x and y, one write and one registered read port.
// Depends on tpst_pkg for the point and port request types.
module tpst_store (
  input  logic              clk_i,
  input  tpst_pkg::wr_req_t wr_i,
  input  tpst_pkg::rd_req_t rd_i,
  output tpst_pkg::point_t  rd_data_o
);
  import tpst_pkg::*;

  logic [TIME_W-1:0] time_mem [MAX_POINTS];
  logic [POS_W-1:0]  x_mem    [MAX_POINTS];
  logic [POS_W-1:0]  y_mem    [MAX_POINTS];
  point_t            rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en_time) begin
      time_mem[wr_i.addr] <= wr_i.data.time_v;
    end
    if (wr_i.en_pos) begin
      x_mem[wr_i.addr] <= wr_i.data.x;
      y_mem[wr_i.addr] <= wr_i.data.y;
    end
    if (rd_i.en) begin
      rd_q.time_v <= time_mem[rd_i.addr];
      rd_q.x      <= x_mem[rd_i.addr];
      rd_q.y      <= y_mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> hdl/tpst_alu.sv
// Shared arithmetic unit: one wide adder and one registered squarer of a - b.
// Depends on tpst_pkg for operand widths.
module tpst_alu (
  input  logic                           clk_i,
  input  logic                           sq_en_i,
  input  logic signed [tpst_pkg::OPW-1:0] a_i,
  input  logic signed [tpst_pkg::OPW-1:0] b_i,
  output logic signed [tpst_pkg::OPW:0]   sum_o,
  output logic [tpst_pkg::SQ_W-1:0]       sq_o
);
  import tpst_pkg::*;

  logic signed [OPW:0]     diff;
  logic signed [DIFF_W-1:0] diff_n;
  logic signed [SQ_W-1:0]   sq_full;
  logic [SQ_W-1:0]          sq_q;

  assign sum_o   = (OPW+1)'(a_i) + (OPW+1)'(b_i);
  assign diff    = (OPW+1)'(a_i) - (OPW+1)'(b_i);
  // Coordinates are narrow, so the difference fits its low bits.
  assign diff_n  = diff[DIFF_W-1:0];
  assign sq_full = diff_n * diff_n;

  always_ff @(posedge clk_i) begin
    if (sq_en_i) begin
      sq_q <= sq_full;
    end
  end

  assign sq_o = sq_q;

endmodule

>>> hdl/trajectory_point_search_table_core.sv
// Trajectory point table: clear, append, errors and unused modes go straight to the
// result; lower-bound reads stored entries in order until it stops, shift reads
// and rewrites every stored entry, and nearest takes each entry through the shared
// squarer in states S_NR_X, S_NR_Y and S_NR_CMP (one memory read per entry). A new
// request is taken only in idle, once the last result is in the output register. Reset
// is asynchronous, active low: clears count, tolerance, control; table undefined.
module trajectory_point_search_table_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpst_in_if.sink    in_ch,
  tpst_out_if.source out_ch,
  tpst_cfg_if.sink   cfg_ch
);
  import tpst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LB_CHK,
    S_NR_X,
    S_NR_Y,
    S_NR_CMP,
    S_SH_WR,
    S_DONE
  } state_e;

  // Sequencer state and registered outputs.
  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [TIME_W-1:0]        last_time_q, last_time_d;
  logic [EPS_W-1:0]         eps_q, eps_d;
  logic [TIME_W-1:0]        op_time_q, op_time_d;
  logic [POS_W-1:0]         op_x_q, op_x_d;
  logic [POS_W-1:0]         op_y_q, op_y_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [DIST_W-1:0]        best_q, best_d;
  logic [IDX_W-1:0]         best_idx_q, best_idx_d;
  logic [SQ_W-1:0]          acc_q, acc_d;
  status_e                  res_status_q, res_status_d;
  logic [IDX_W-1:0]         res_idx_q, res_idx_d;
  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q, out_status_d;
  logic [FIDX_W-1:0]        out_idx_q, out_idx_d;
  logic [PCNT_W-1:0]        out_cnt_q, out_cnt_d;

  // Datapath controls.
  wr_req_t                  wr_req;
  rd_req_t                  rd_req;
  point_t                   rd_data;
  logic                     sq_en;
  logic signed [OPW-1:0]    alu_a, alu_b;
  logic signed [OPW:0]      alu_sum;
  logic [SQ_W-1:0]          alu_sq;

  logic                     in_acc;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         idx_inc;
  logic                     cnt_empty;
  logic                     cnt_full;
  logic                     lb_hit;
  logic [DIST_W-1:0]        dist_sum;
  logic                     nr_better;
  logic [TIME_W-1:0]        sat_time;

  assign in_ch.ready  = (state_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign last_idx  = IDX_W'(cnt_q - CNT_W'(1));
  assign idx_inc   = idx_q + IDX_W'(1);
  assign cnt_empty = (cnt_q == '0);
  assign cnt_full  = (cnt_q >= CNT_W'(MAX_POINTS));

  // Interpretations of the shared adder per state.
  assign lb_hit    = (alu_sum >= (OPW+1)'($signed(op_time_q)));
  assign dist_sum  = alu_sum[DIST_W-1:0];
  assign nr_better = (idx_q == '0) || (dist_sum < best_q);

  always_comb begin
    if (alu_sum > (OPW+1)'(TIME_MAX)) begin
      sat_time = TIME_MAX;
    end else if (alu_sum < (OPW+1)'(TIME_MIN)) begin
      sat_time = TIME_MIN;
    end else begin
      sat_time = alu_sum[TIME_W-1:0];
    end
  end

  // Operand select for the shared unit.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    sq_en = 1'b0;
    unique case (state_q)
      S_LB_CHK: begin
        alu_a = OPW'($signed(rd_data.time_v));
        alu_b = OPW'(eps_q);
      end
      S_SH_WR: begin
        alu_a = OPW'($signed(rd_data.time_v));
        alu_b = OPW'($signed(op_time_q));
      end
      S_NR_X: begin
        alu_a = OPW'($signed(rd_data.x));
        alu_b = OPW'($signed(op_x_q));
        sq_en = 1'b1;
      end
      S_NR_Y: begin
        alu_a = OPW'($signed(rd_data.y));
        alu_b = OPW'($signed(op_y_q));
        sq_en = 1'b1;
      end
      S_NR_CMP: begin
        alu_a = OPW'(acc_q);
        alu_b = OPW'(alu_sq);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    last_time_d  = last_time_q;
    eps_d        = eps_q;
    op_time_d    = op_time_q;
    op_x_d       = op_x_q;
    op_y_d       = op_y_q;
    idx_d        = idx_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    acc_d        = acc_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_cnt_d    = out_cnt_q;
    wr_req       = '0;
    rd_req       = '0;

    if (cfg_ch.valid) begin
      eps_d = cfg_ch.time_epsilon;
    end

    // Drop the result once the sink takes it.
    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_time_d    = in_ch.time_value;
          op_x_d       = in_ch.pos_x;
          op_y_d       = in_ch.pos_y;
          idx_d        = '0;
          res_status_d = ST_OK;
          res_idx_d    = '0;
          state_d      = S_DONE;
          unique case (mode_e'(in_ch.mode))
            MODE_CLEAR: begin
              cnt_d = '0;
            end
            MODE_APPEND: begin
              // Full check comes before the time-order check.
              if (cnt_full) begin
                res_status_d = ST_FULL;
              end else if (!cnt_empty &&
                           (in_ch.time_value <= $signed(last_time_q))) begin
                res_status_d = ST_ORDER;
              end else begin
                wr_req.en_time     = 1'b1;
                wr_req.en_pos      = 1'b1;
                wr_req.addr        = IDX_W'(cnt_q);
                wr_req.data.time_v = in_ch.time_value;
                wr_req.data.x      = in_ch.pos_x;
                wr_req.data.y      = in_ch.pos_y;
                cnt_d              = cnt_q + CNT_W'(1);
                last_time_d        = in_ch.time_value;
              end
            end
            MODE_LOWER: begin
              if (cnt_empty) begin
                res_status_d = ST_EMPTY;
              end else if (in_ch.time_value >= $signed(last_time_q)) begin
                // Query at or past the last point: answer the last index.
                res_idx_d = last_idx;
              end else begin
                rd_req.en = 1'b1;
                state_d   = S_LB_CHK;
              end
            end
            MODE_NEAR: begin
              if (cnt_empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_req.en = 1'b1;
                state_d   = S_NR_X;
              end
            end
            MODE_SHIFT: begin
              if (!cnt_empty) begin
                rd_req.en = 1'b1;
                state_d   = S_SH_WR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_LB_CHK: begin
        // Stop at the first entry whose widened time reaches the query.
        if (lb_hit || (idx_q == last_idx)) begin
          res_idx_d = idx_q;
          state_d   = S_DONE;
        end else begin
          idx_d       = idx_inc;
          rd_req.en   = 1'b1;
          rd_req.addr = idx_inc;
        end
      end

      S_NR_X: begin
        state_d = S_NR_Y;
      end

      S_NR_Y: begin
        // Hold dx squared while the squarer takes dy.
        acc_d   = alu_sq;
        state_d = S_NR_CMP;
      end

      S_NR_CMP: begin
        if (nr_better) begin
          best_d     = dist_sum;
          best_idx_d = idx_q;
        end
        if (idx_q == last_idx) begin
          res_idx_d = nr_better ? idx_q : best_idx_q;
          state_d   = S_DONE;
        end else begin
          idx_d       = idx_inc;
          rd_req.en   = 1'b1;
          rd_req.addr = idx_inc;
          state_d     = S_NR_X;
        end
      end

      S_SH_WR: begin
        // Write back the saturated time and fetch the next entry.
        wr_req.en_time     = 1'b1;
        wr_req.addr        = idx_q;
        wr_req.data.time_v = sat_time;
        if (idx_q == last_idx) begin
          last_time_d = sat_time;
          state_d     = S_DONE;
        end else begin
          idx_d       = idx_inc;
          rd_req.en   = 1'b1;
          rd_req.addr = idx_inc;
        end
      end

      S_DONE: begin
        // Advance into the output register when it is free.
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = (res_status_q == ST_OK) ? FIDX_W'(res_idx_q) : '0;
          out_cnt_d    = PCNT_W'(cnt_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      last_time_q  <= '0;
      eps_q        <= '0;
      op_time_q    <= '0;
      op_x_q       <= '0;
      op_y_q       <= '0;
      idx_q        <= '0;
      best_q       <= '0;
      best_idx_q   <= '0;
      acc_q        <= '0;
      res_status_q <= ST_OK;
      res_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_idx_q    <= '0;
      out_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      last_time_q  <= last_time_d;
      eps_q        <= eps_d;
      op_time_q    <= op_time_d;
      op_x_q       <= op_x_d;
      op_y_q       <= op_y_d;
      idx_q        <= idx_d;
      best_q       <= best_d;
      best_idx_q   <= best_idx_d;
      acc_q        <= acc_d;
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_d;
      out_cnt_q    <= out_cnt_d;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.status      = out_status_q;
  assign out_ch.found_index = out_idx_q;
  assign out_ch.point_count = out_cnt_q;

  tpst_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_i      (rd_req),
    .rd_data_o (rd_data)
  );

  tpst_alu u_alu (
    .clk_i   (clk_i),
    .sq_en_i (sq_en),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .sq_o    (alu_sq)
  );

endmodule

>>> hdl/tpst_checker.sv
// Port-level checks of the trajectory point table, bound to the top level.
// Depends on tpst_pkg for status codes and the table depth.
module tpst_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [tpst_pkg::STAT_W-1:0] status_i,
  input logic [tpst_pkg::FIDX_W-1:0] found_index_i,
  input logic [tpst_pkg::PCNT_W-1:0] point_count_i
);
  import tpst_pkg::*;

  // A taken request leaves the block busy, so ready drops in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while the previous one was in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (found_index_i == '0))
    else $error("error result carries a nonzero index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY) |-> (point_count_i == '0))
    else $error("empty status with points held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |-> (int'(point_count_i) == MAX_POINTS))
    else $error("full status below table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(found_index_i) && $stable(point_count_i))
    else $error("stalled result changed");

endmodule

bind trajectory_point_search_table_core tpst_checker u_tpst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .status_i      (out_ch.status),
  .found_index_i (out_ch.found_index),
  .point_count_i (out_ch.point_count)
);

>>> verif/tb_trajectory_point_search_table_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for trajectory_point_search_table_core: random and directed table
// operations with an internal predictor. Depends on tpst_pkg, the tpst_*_if interfaces and the core.
module tb_trajectory_point_search_table_core;
  import tpst_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // idle cycles before the run is dropped
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off that backs up the block
  localparam int RANDOM_ITEMS   = 1500;
  localparam int DRAIN_CYCLES   = 50;

  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [EPS_W-1:0] EPS_MAX = '1;

  // Entries of the stimulus plan: a request, a tolerance write, a pause until all
  // results are back, or a trigger for the long receiver hold-off.
  typedef enum logic [1:0] {STEP_REQUEST, STEP_EPSILON, STEP_SETTLE, STEP_BACKPRESSURE}
    step_kind_e;

  typedef struct packed {
    step_kind_e               kind;
    logic [MODE_W-1:0]        mode;
    logic signed [TIME_W-1:0] t;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [EPS_W-1:0]         eps;
  } step_t;

  typedef struct packed {
    status_e           status;
    logic [FIDX_W-1:0] idx;
    logic [PCNT_W-1:0] count;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  tpst_in_if  req_ch();
  tpst_out_if res_ch();
  tpst_cfg_if eps_ch();

  trajectory_point_search_table_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (eps_ch)
  );

  // Stimulus plan and the outcomes still owed by the block.
  step_t    plan_q[$];
  outcome_t outcome_q[$];
  int       fail_count;

  // Predictor state: the table as the block should hold it.
  logic signed [TIME_W-1:0] shadow_time [MAX_POINTS];
  logic signed [POS_W-1:0]  shadow_x    [MAX_POINTS];
  logic signed [POS_W-1:0]  shadow_y    [MAX_POINTS];
  int                       shadow_count;
  logic [EPS_W-1:0]         shadow_eps;

  // Generator view of the stored times, used only to aim appends and queries.
  logic signed [TIME_W-1:0] gen_times[$];
  int                       n_planned;

  // Handshakes seen at the last rising edge, read by the falling-edge drivers.
  logic in_taken, out_taken, cfg_taken;
  int   hold_req, hold_seen;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Signed add that clamps to the 32-bit time range, as the shift mode does.
  function automatic logic signed [TIME_W-1:0] sat_add(input logic signed [TIME_W-1:0] a,
                                                       input logic signed [TIME_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(TIME_MAX)) return TIME_MAX;
    if (s < longint'(TIME_MIN)) return TIME_MIN;
    return s[TIME_W-1:0];
  endfunction

  // Idle length after a handshake: mostly short, a few long, with calm stretches
  // in which no gap is inserted at all.
  function automatic int idle_span(inout int stretch, inout bit calm);
    int r;
    if (stretch == 0) begin
      calm    = ($urandom_range(0, 3) == 0);
      stretch = $urandom_range(10, 60);
    end
    stretch--;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Apply one accepted request to the shadow table and queue the outcome it owes.
  task automatic predict_outcome(input logic [MODE_W-1:0] op,
                                 input logic signed [TIME_W-1:0] t,
                                 input logic signed [POS_W-1:0] px,
                                 input logic signed [POS_W-1:0] py);
    outcome_t o;
    int       i, last, hit;
    longint   dx, dy, d, best_d;
    o.status = ST_OK;
    o.idx    = '0;
    last     = shadow_count - 1;
    case (op)
      MODE_CLEAR: shadow_count = 0;
      MODE_APPEND: begin
        // Full takes precedence over the time-order check.
        if (shadow_count >= MAX_POINTS) begin
          o.status = ST_FULL;
        end else if (shadow_count > 0 && t <= shadow_time[last]) begin
          o.status = ST_ORDER;
        end else begin
          shadow_time[shadow_count] = t;
          shadow_x[shadow_count]    = px;
          shadow_y[shadow_count]    = py;
          shadow_count++;
        end
      end
      MODE_LOWER: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else if (t >= shadow_time[last]) begin
          o.idx = last[FIDX_W-1:0];
        end else begin
          // First entry whose widened time reaches the query; sum kept wide.
          hit = last;
          for (i = last; i >= 0; i--)
            if (longint'(shadow_time[i]) + longint'(shadow_eps) >= longint'(t)) hit = i;
          o.idx = hit[FIDX_W-1:0];
        end
      end
      MODE_NEAR: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          hit    = 0;
          best_d = 0;
          for (i = 0; i < shadow_count; i++) begin
            dx = longint'(shadow_x[i]) - longint'(px);
            dy = longint'(shadow_y[i]) - longint'(py);
            d  = dx * dx + dy * dy;
            // Strict compare keeps the lowest index on a tie.
            if (i == 0 || d < best_d) begin
              best_d = d;
              hit    = i;
            end
          end
          o.idx = hit[FIDX_W-1:0];
        end
      end
      MODE_SHIFT: begin
        for (i = 0; i < shadow_count; i++) shadow_time[i] = sat_add(shadow_time[i], t);
      end
      default: ;  // unused modes leave the table alone
    endcase
    o.count = shadow_count[PCNT_W-1:0];
    outcome_q.insert(outcome_q.size(), o);
  endtask

  // Queue a request and keep the generator's view of the stored times in step.
  task automatic plan_request(input logic [MODE_W-1:0] op, input logic signed [TIME_W-1:0] t,
                              input logic signed [POS_W-1:0] px,
                              input logic signed [POS_W-1:0] py);
    step_t s;
    s      = '0;
    s.kind = STEP_REQUEST;
    s.mode = op;
    s.t    = t;
    s.x    = px;
    s.y    = py;
    plan_q.insert(plan_q.size(), s);
    n_planned++;
    case (op)
      MODE_CLEAR: gen_times.delete();
      MODE_APPEND:
        if (gen_times.size() < MAX_POINTS && (gen_times.size() == 0 || t > gen_times[$]))
          gen_times.insert(gen_times.size(), t);
      MODE_SHIFT: foreach (gen_times[i]) gen_times[i] = sat_add(gen_times[i], t);
      default: ;
    endcase
  endtask

  task automatic plan_marker(input step_kind_e kind, input logic [EPS_W-1:0] eps);
    step_t s;
    s      = '0;
    s.kind = kind;
    s.eps  = eps;
    plan_q.insert(plan_q.size(), s);
  endtask

  // Coordinates on a coarse grid often, so equal distances and ties come up.
  function automatic logic signed [POS_W-1:0] pick_coord();
    int r, v;
    r = $urandom_range(0, 9);
    v = $urandom;
    if (r < 5) v = ($urandom_range(0, 15) - 8) * 300;
    else if (r == 7) v = POS_MAX;
    else if (r == 8) v = POS_MIN;
    else if (r == 9) v = 0;
    return v[POS_W-1:0];
  endfunction

  // Mostly strictly later than the last time; now and then equal or earlier.
  function automatic logic signed [TIME_W-1:0] pick_append_time();
    int r, v;
    r = $urandom_range(0, 19);
    if (gen_times.size() == 0) begin
      v = $urandom_range(0, 20000) - 10000;
      if (r == 0) v = $urandom;
      if (r == 1) v = TIME_MIN;
      return v;
    end
    if (r == 0) return gen_times[$];
    if (r == 1) return sat_add(gen_times[$], -$urandom_range(1, 5000));
    return sat_add(gen_times[$], $urandom_range(1, 3000));
  endfunction

  // Query times near stored ones, exact hits, past the end, or anywhere.
  function automatic logic signed [TIME_W-1:0] pick_query_time();
    int                       r, off;
    logic signed [TIME_W-1:0] k;
    r = $urandom_range(0, 9);
    if (gen_times.size() == 0 || r < 2) return $urandom;
    k   = gen_times[$urandom_range(0, gen_times.size() - 1)];
    off = $urandom_range(0, 140000) - 70000;
    if (r < 5) return k;
    if (r < 8) return sat_add(k, off);
    return sat_add(gen_times[$], $urandom_range(0, 5));
  endfunction

  function automatic logic signed [TIME_W-1:0] pick_shift();
    int r, v;
    r = $urandom_range(0, 9);
    v = $urandom_range(0, 10000) - 5000;
    if (r == 8) v = $urandom;
    if (r == 9) v = $urandom_range(0, 1) ? TIME_MAX : TIME_MIN;
    return v;
  endfunction

  task automatic plan_query_mix(input int m);
    int r;
    repeat (m) begin
      r = $urandom_range(0, 99);
      if (r < 35) plan_request(MODE_LOWER, pick_query_time(), pick_coord(), pick_coord());
      else if (r < 65) plan_request(MODE_NEAR, $urandom, pick_coord(), pick_coord());
      else if (r < 77) plan_request(MODE_SHIFT, pick_shift(), pick_coord(), pick_coord());
      else if (r < 97) plan_request(MODE_APPEND, pick_append_time(), pick_coord(), pick_coord());
      else plan_request(MODE_CLEAR, $urandom, pick_coord(), pick_coord());
    end
  endtask

  // Clear, fill to capacity, push past it, then query and shift the full table.
  task automatic plan_fill();
    plan_request(MODE_CLEAR, 0, 0, 0);
    repeat (MAX_POINTS)
      plan_request(MODE_APPEND, gen_times.size() == 0 ? 0 : sat_add(gen_times[$],
                   $urandom_range(1, 100)), pick_coord(), pick_coord());
    plan_request(MODE_APPEND, sat_add(gen_times[$], 1), pick_coord(), pick_coord());
    // Out of order and full at once: full must win.
    plan_request(MODE_APPEND, TIME_MIN, pick_coord(), pick_coord());
    plan_request(MODE_LOWER, pick_query_time(), 0, 0);
    plan_request(MODE_LOWER, gen_times[$], 0, 0);
    plan_request(MODE_NEAR, 0, pick_coord(), pick_coord());
    plan_request(MODE_NEAR, 0, POS_MAX, POS_MIN);
    plan_request(MODE_SHIFT, pick_shift(), 0, 0);
    plan_request(MODE_LOWER, pick_query_time(), 0, 0);
  endtask

  task automatic build_plan();
    int seq, k, r;
    // Directed: empty table first, with the tolerance still at its reset value.
    plan_request(MODE_LOWER, 0, 0, 0);
    plan_request(MODE_NEAR, 0, POS_MAX, POS_MAX);
    plan_request(MODE_SHIFT, 12345, 0, 0);
    plan_request(MODE_CLEAR, 0, 0, 0);
    plan_request(MODE_UNUSED_FIRST, TIME_MAX, POS_MAX, POS_MIN);
    plan_request(MODE_UNUSED_LAST, TIME_MIN, POS_MIN, POS_MAX);
    // Extreme times and positions; two points share a position for a nearest tie.
    plan_request(MODE_APPEND, TIME_MIN, POS_MIN, POS_MAX);
    plan_request(MODE_APPEND, TIME_MIN, 0, 0);
    plan_request(MODE_APPEND, -5, POS_MAX, POS_MIN);
    plan_request(MODE_APPEND, 100, POS_MAX, POS_MIN);
    plan_request(MODE_APPEND, TIME_MAX, 0, 0);
    plan_request(MODE_APPEND, TIME_MAX, 0, 0);
    plan_request(MODE_LOWER, TIME_MAX, 0, 0);
    plan_request(MODE_LOWER, TIME_MIN, 0, 0);
    plan_request(MODE_LOWER, 50, 0, 0);
    plan_request(MODE_NEAR, 0, POS_MAX, POS_MIN);
    plan_request(MODE_NEAR, 0, POS_MIN, POS_MAX);
    // Widest tolerance, then saturating shifts both ways that leave equal times.
    plan_marker(STEP_EPSILON, EPS_MAX);
    plan_request(MODE_LOWER, 50, 0, 0);
    plan_request(MODE_LOWER, 70000, 0, 0);
    plan_request(MODE_SHIFT, TIME_MAX, 0, 0);
    plan_request(MODE_LOWER, 0, 0, 0);
    plan_request(MODE_SHIFT, TIME_MIN, 0, 0);
    plan_request(MODE_SHIFT, TIME_MIN, 0, 0);
    plan_request(MODE_LOWER, TIME_MIN, 0, 0);
    plan_marker(STEP_EPSILON, '0);
    plan_request(MODE_W'(MODE_UNUSED_FIRST + 1), 0, 0, 0);

    // Random part: mostly well-formed runs (clear, ordered appends, queries),
    // the rest noise with every field and mode fully random.
    k   = n_planned + RANDOM_ITEMS;
    seq = 0;
    while (n_planned < k) begin
      seq++;
      r = $urandom_range(0, 99);
      if (seq == 2 || r == 0) begin
        plan_fill();
      end else if (r < 72) begin
        if ($urandom_range(0, 3) != 0) plan_request(MODE_CLEAR, $urandom, 0, 0);
        r = $urandom_range(0, 99);
        repeat (r < 70 ? $urandom_range(1, 8) : r < 95 ? $urandom_range(9, 40) :
                $urandom_range(41, 100))
          plan_request(MODE_APPEND, pick_append_time(), pick_coord(), pick_coord());
        plan_query_mix($urandom_range(1, 10));
      end else begin
        repeat ($urandom_range(1, 8))
          plan_request(MODE_W'($urandom_range(0, 7)), $urandom, POS_W'($urandom),
                       POS_W'($urandom));
      end
      if ($urandom_range(0, 11) == 0) begin
        r = $urandom_range(0, 3);
        plan_marker(STEP_EPSILON, r == 0 ? '0 : r == 1 ? EPS_MAX : EPS_W'($urandom));
      end
      if (seq % 25 == 0) plan_marker(STEP_SETTLE, '0);
      if (seq == 4 || seq == 60) plan_marker(STEP_BACKPRESSURE, '0);
    end
  endtask

  // Rising edge: record handshakes, check results, feed the predictor.
  always @(posedge clk_i) begin : handshake_monitor
    outcome_t exp_o;
    in_taken  <= rst_ni && req_ch.valid && req_ch.ready;
    out_taken <= rst_ni && res_ch.valid && res_ch.ready;
    cfg_taken <= rst_ni && eps_ch.valid && eps_ch.ready;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result: status %0d index %0d count %0d",
                 res_ch.status, res_ch.found_index, res_ch.point_count);
          fail_count++;
        end else begin
          exp_o = outcome_q.pop_front();
          if (res_ch.status !== exp_o.status) begin
            $error("status: expected %0d, got %0d", exp_o.status, res_ch.status);
            fail_count++;
          end
          if (res_ch.found_index !== exp_o.idx) begin
            $error("found_index: expected %0d, got %0d", exp_o.idx, res_ch.found_index);
            fail_count++;
          end
          if (res_ch.point_count !== exp_o.count) begin
            $error("point_count: expected %0d, got %0d", exp_o.count, res_ch.point_count);
            fail_count++;
          end
        end
      end
      if (eps_ch.valid && eps_ch.ready) shadow_eps = eps_ch.time_epsilon;
      if (req_ch.valid && req_ch.ready)
        predict_outcome(req_ch.mode, req_ch.time_value, req_ch.pos_x, req_ch.pos_y);
    end
  end

  // Falling edge: advance the plan. Hold a request until it is taken; write the
  // tolerance and pass settle points only once every owed result is back.
  always @(negedge clk_i) begin : request_driver
    static int req_gap = 0;
    static int tx_stretch = 0;
    static bit tx_calm = 1'b0;
    step_t     head;
    logic      nxt_valid, nxt_cfg_valid, drained;
    nxt_valid     = req_ch.valid;
    nxt_cfg_valid = eps_ch.valid;
    if (rst_ni) begin
      if (in_taken) begin
        nxt_valid = 1'b0;
        req_gap   = idle_span(tx_stretch, tx_calm);
      end
      if (cfg_taken) nxt_cfg_valid = 1'b0;
      drained = (outcome_q.size() == 0);
      if (!nxt_valid && !nxt_cfg_valid && plan_q.size() > 0) begin
        head = plan_q[0];
        case (head.kind)
          STEP_REQUEST: begin
            if (req_gap > 0) begin
              req_gap--;
            end else begin
              req_ch.mode       <= head.mode;
              req_ch.time_value <= head.t;
              req_ch.pos_x      <= head.x;
              req_ch.pos_y      <= head.y;
              nxt_valid = 1'b1;
              void'(plan_q.pop_front());
            end
          end
          STEP_EPSILON: begin
            if (drained) begin
              eps_ch.time_epsilon <= head.eps;
              nxt_cfg_valid = 1'b1;
              void'(plan_q.pop_front());
            end
          end
          STEP_SETTLE: if (drained) void'(plan_q.pop_front());
          default: begin
            hold_req <= hold_req + 1;
            void'(plan_q.pop_front());
          end
        endcase
      end
    end
    req_ch.valid <= nxt_valid;
    eps_ch.valid <= nxt_cfg_valid;
  end

  // Falling edge: result ready with random stalls and the long hold-off on request.
  always @(negedge clk_i) begin : result_receiver
    static int rx_gap = 0;
    static int hold_left = 0;
    static int rx_stretch = 0;
    static bit rx_calm = 1'b0;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (out_taken) rx_gap = idle_span(rx_stretch, rx_calm);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Drop the run if no handshake of any kind happens for too long.
  always @(posedge clk_i) begin : watchdog
    static int quiet = 0;
    if (in_taken || out_taken || cfg_taken || !rst_ni) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_trajectory_point_search_table_core NOT OK");
      $finish;
    end
  end

  initial begin : run_control
    fail_count   = 0;
    n_planned    = 0;
    shadow_count = 0;
    shadow_eps   = '0;
    hold_req     = 0;
    hold_seen    = 0;
    in_taken     = 1'b0;
    out_taken    = 1'b0;
    cfg_taken    = 1'b0;
    rst_ni       = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.mode         = '0;
    req_ch.time_value   = '0;
    req_ch.pos_x        = '0;
    req_ch.pos_y        = '0;
    res_ch.ready        = 1'b0;
    eps_ch.valid        = 1'b0;
    eps_ch.time_epsilon = '0;
    build_plan();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Wait out the plan and every owed result, then let the block run dry.
    while (plan_q.size() > 0 || req_ch.valid || eps_ch.valid || outcome_q.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_trajectory_point_search_table_core OK");
    end else begin
      $display("tb_trajectory_point_search_table_core NOT OK");
    end
    $finish;
  end

endmodule
